FILE: src/iuz_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the image upscaler.
// No dependencies; every other file of the block except iuz_ram imports this package.
package iuz_pkg;

  localparam int CH_BITS        = 16;
  localparam int FRAC_BITS      = 16;
  localparam int COORD_BITS     = 12;
  localparam int SDIM_BITS      = 9;
  localparam int TDIM_BITS      = 13;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 13;
  localparam int MAX_TARGET_DIM = 4096;
  localparam int FIFO_DEPTH     = 4;

  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SRC_W    = 3'd0,
    CFG_SRC_H    = 3'd1,
    CFG_TGT_W    = 3'd2,
    CFG_TGT_H    = 3'd3,
    CFG_BILINEAR = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_PRODUCE = 1'b1
  } mode_e;

  typedef logic [CH_BITS-1:0] chan_t;
  // index 3 red, 2 green, 1 blue, 0 alpha
  typedef chan_t [3:0] pixel_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  source_x;
    logic [7:0]  source_y;
    logic [11:0] target_x;
    logic [11:0] target_y;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
    logic        dims_error;
  } out_item_t;

  typedef struct packed {
    logic [SDIM_BITS-1:0] src_w;
    logic [SDIM_BITS-1:0] src_h;
    logic [TDIM_BITS-1:0] tgt_w;
    logic [TDIM_BITS-1:0] tgt_h;
    logic                 bilinear;
  } cfg_t;

  // One classified job handed from the address front to the datapath back.
  typedef struct packed {
    logic                  is_load;
    logic                  load_ok;
    logic                  err;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic                  x_same;
    logic                  y_same;
    logic [FRAC_BITS-1:0]  fx;
    logic [FRAC_BITS-1:0]  fy;
    pixel_t                pix;
  } job_t;

endpackage

FILE: src/iuz_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iuz_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/iuz_front.sv
`timescale 1ns / 1ps
// Address front: accepts items, clamps targets, scales and divides the
// coordinates in a bit-per-stage pipeline and emits classified jobs. Uses iuz_pkg.
module iuz_front
  import iuz_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     q_space_i,
  output logic     q_push_o,
  output job_t     q_job_o
);

  localparam int IBX       = $clog2(MAX_SOURCE_WIDTH);
  localparam int IBY       = $clog2(MAX_SOURCE_HEIGHT);
  localparam int IB        = (IBX > IBY) ? IBX : IBY;
  localparam int STEPS     = IB + FRAC_BITS;
  localparam int NUM_BITS  = COORD_BITS + SDIM_BITS;
  localparam int DEN_BITS  = TDIM_BITS;
  localparam int WORK_BITS = DEN_BITS + STEPS;

  typedef struct packed {
    logic       is_load;
    logic       load_ok;
    logic       err;
    logic [7:0] sx;
    logic [7:0] sy;
    pixel_t     pix;
  } tag_t;

  typedef logic [WORK_BITS-1:0] work_t;

  // One restoring step: shift in the next bit, subtract when it fits.
  function automatic work_t div_step(work_t w, logic [DEN_BITS-1:0] den);
    logic [DEN_BITS:0]   part;
    logic [DEN_BITS:0]   diff;
    logic [DEN_BITS-1:0] rem;
    logic [STEPS-1:0]    low;
    part = {w[WORK_BITS-1 -: DEN_BITS], w[STEPS-1]};
    diff = part - {1'b0, den};
    if (part >= {1'b0, den}) begin
      rem = diff[DEN_BITS-1:0];
      low = {w[STEPS-2:0], 1'b1};
    end else begin
      rem = part[DEN_BITS-1:0];
      low = {w[STEPS-2:0], 1'b0};
    end
    return {rem, low};
  endfunction

  function automatic work_t div_init(logic [NUM_BITS-1:0] num);
    return {DEN_BITS'(num >> IB), num[IB-1:0], {FRAC_BITS{1'b0}}};
  endfunction

  logic                  en;
  logic [SDIM_BITS-1:0]  mul_x, mul_y;
  logic [DEN_BITS-1:0]   den_x, den_y;
  logic [TDIM_BITS-1:0]  tw_m1, th_m1;
  logic                  dims_ok;
  logic [COORD_BITS-1:0] tx_c, ty_c;
  tag_t                  tag_in;

  logic                  v0_q;
  tag_t                  tag0_q;
  logic [COORD_BITS-1:0] tx0_q, ty0_q;
  logic                  v1_q;
  tag_t                  tag1_q;
  logic [NUM_BITS-1:0]   numx1_q, numy1_q;

  logic                  dv_q  [STEPS];
  tag_t                  dtag_q[STEPS];
  work_t                 wx_q  [STEPS];
  work_t                 wy_q  [STEPS];
  work_t                 wx_d  [STEPS];
  work_t                 wy_d  [STEPS];

  // User makes configuration changes only while idle (unenforced): scales static.
  always_comb begin
    mul_x = cfg_i.bilinear ? cfg_i.src_w - 1'b1 : cfg_i.src_w;
    mul_y = cfg_i.bilinear ? cfg_i.src_h - 1'b1 : cfg_i.src_h;
    den_x = cfg_i.bilinear ? cfg_i.tgt_w - 1'b1 : cfg_i.tgt_w;
    den_y = cfg_i.bilinear ? cfg_i.tgt_h - 1'b1 : cfg_i.tgt_h;
    tw_m1 = cfg_i.tgt_w - 1'b1;
    th_m1 = cfg_i.tgt_h - 1'b1;
    dims_ok = 1'b1;
    if (cfg_i.bilinear) begin
      if (cfg_i.src_w < SDIM_BITS'(2) || cfg_i.src_h < SDIM_BITS'(2) ||
          cfg_i.tgt_w < TDIM_BITS'(2) || cfg_i.tgt_h < TDIM_BITS'(2)) begin
        dims_ok = 1'b0;
      end
    end
    if (cfg_i.src_w == '0 || int'(cfg_i.src_w) > MAX_SOURCE_WIDTH ||
        cfg_i.src_h == '0 || int'(cfg_i.src_h) > MAX_SOURCE_HEIGHT ||
        cfg_i.tgt_w == '0 || int'(cfg_i.tgt_w) > MAX_TARGET_DIM ||
        cfg_i.tgt_h == '0 || int'(cfg_i.tgt_h) > MAX_TARGET_DIM) begin
      dims_ok = 1'b0;
    end
    if (TDIM_BITS'(cfg_i.src_w) > cfg_i.tgt_w ||
        TDIM_BITS'(cfg_i.src_h) > cfg_i.tgt_h) begin
      dims_ok = 1'b0;
    end
  end

  always_comb begin
    tx_c = ({1'b0, in_data_i.target_x} > tw_m1) ? tw_m1[COORD_BITS-1:0]
                                                 : in_data_i.target_x;
    ty_c = ({1'b0, in_data_i.target_y} > th_m1) ? th_m1[COORD_BITS-1:0]
                                                 : in_data_i.target_y;
    tag_in.is_load = (mode_e'(in_data_i.mode) == MODE_LOAD);
    tag_in.load_ok = (int'(in_data_i.source_x) < MAX_SOURCE_WIDTH) &&
                     (int'(in_data_i.source_y) < MAX_SOURCE_HEIGHT);
    tag_in.err     = !dims_ok;
    tag_in.sx      = in_data_i.source_x;
    tag_in.sy      = in_data_i.source_y;
    tag_in.pix     = {in_data_i.red_in, in_data_i.green_in,
                      in_data_i.blue_in, in_data_i.alpha_in};
  end

  // Advance the whole front unless the tail job cannot enter the queue.
  assign en         = q_space_i || !dv_q[STEPS-1];
  assign in_ready_o = en;

  always_comb begin
    wx_d[0] = div_step(div_init(numx1_q), den_x);
    wy_d[0] = div_step(div_init(numy1_q), den_y);
    for (int k = 1; k < STEPS; k++) begin
      wx_d[k] = div_step(wx_q[k-1], den_x);
      wy_d[k] = div_step(wy_q[k-1], den_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      for (int k = 0; k < STEPS; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (en) begin
      v0_q    <= in_valid_i;
      v1_q    <= v0_q;
      dv_q[0] <= v1_q;
      for (int k = 1; k < STEPS; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag0_q    <= tag_in;
      tx0_q     <= tx_c;
      ty0_q     <= ty_c;
      tag1_q    <= tag0_q;
      numx1_q   <= NUM_BITS'(tx0_q * mul_x);
      numy1_q   <= NUM_BITS'(ty0_q * mul_y);
      dtag_q[0] <= tag1_q;
      for (int k = 1; k < STEPS; k++) begin
        dtag_q[k] <= dtag_q[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
        wx_q[k] <= wx_d[k];
        wy_q[k] <= wy_d[k];
      end
    end
  end

  logic [STEPS-1:0]      qx, qy;
  logic [COORD_BITS-1:0] xq, yq;
  logic [COORD_BITS:0]   xq_p1, yq_p1;
  tag_t                  tl;

  always_comb begin
    tl    = dtag_q[STEPS-1];
    qx    = wx_q[STEPS-1][STEPS-1:0];
    qy    = wy_q[STEPS-1][STEPS-1:0];
    xq    = COORD_BITS'(qx[STEPS-1:FRAC_BITS]);
    yq    = COORD_BITS'(qy[STEPS-1:FRAC_BITS]);
    xq_p1 = {1'b0, xq} + {{COORD_BITS{1'b0}}, 1'b1};
    yq_p1 = {1'b0, yq} + {{COORD_BITS{1'b0}}, 1'b1};

    q_job_o.is_load = tl.is_load;
    q_job_o.load_ok = tl.load_ok;
    q_job_o.err     = tl.err;
    q_job_o.pix     = tl.pix;
    if (tl.is_load) begin
      q_job_o.x0     = COORD_BITS'(tl.sx);
      q_job_o.y0     = COORD_BITS'(tl.sy);
      q_job_o.x_same = 1'b1;
      q_job_o.y_same = 1'b1;
      q_job_o.fx     = '0;
      q_job_o.fy     = '0;
    end else begin
      q_job_o.x0     = xq;
      q_job_o.y0     = yq;
      // clamp the second neighbor at the last column and row
      q_job_o.x_same = !cfg_i.bilinear || !(xq_p1 < (COORD_BITS+1)'(cfg_i.src_w));
      q_job_o.y_same = !cfg_i.bilinear || !(yq_p1 < (COORD_BITS+1)'(cfg_i.src_h));
      q_job_o.fx     = cfg_i.bilinear ? qx[FRAC_BITS-1:0] : '0;
      q_job_o.fy     = cfg_i.bilinear ? qy[FRAC_BITS-1:0] : '0;
    end
  end

  assign q_push_o = en && dv_q[STEPS-1];

endmodule

FILE: src/iuz_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the address front and the datapath back.
// Uses iuz_pkg for the job type.
module iuz_fifo
  import iuz_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic space_o,
  input  logic pop_i,
  output logic avail_o,
  output job_t job_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  job_t          slot_q[FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign avail_o = (cnt_q != '0);
  assign space_o = (cnt_q != CW'(FIFO_DEPTH)) || pop_i;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule

FILE: src/iuz_back.sv
`timescale 1ns / 1ps
// Datapath back: four parity banks of the source store, neighbor weighting,
// rounding and the output register. Uses iuz_pkg and iuz_ram.
module iuz_back
  import iuz_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      avail_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int BW       = (MAX_SOURCE_WIDTH + 1) / 2;
  localparam int BH       = (MAX_SOURCE_HEIGHT + 1) / 2;
  localparam int BDEPTH   = BW * BH;
  localparam int AW       = $clog2(BDEPTH);
  localparam int W_BITS   = 2 * FRAC_BITS + 1;
  localparam int ACC_BITS = CH_BITS + W_BITS;
  localparam int PIX_BITS = 4 * CH_BITS;

  typedef logic [W_BITS-1:0]   wgt_t;
  typedef logic [ACC_BITS-1:0] acc_t;

  logic en;
  assign en    = !out_valid_o || out_ready_i;
  assign pop_o = en && avail_i;

  // Bank addressing: bank [row parity][column parity].
  logic [COORD_BITS-1:0] x1, y1;
  logic [COORD_BITS-1:0] cx[2];
  logic [COORD_BITS-1:0] ry[2];
  pixel_t                rd[2][2];

  always_comb begin
    x1 = job_i.x_same ? job_i.x0 : job_i.x0 + 1'b1;
    y1 = job_i.y_same ? job_i.y0 : job_i.y0 + 1'b1;
    for (int p = 0; p < 2; p++) begin
      cx[p] = (job_i.x0[0] == p[0]) ? job_i.x0 : x1;
      ry[p] = (job_i.y0[0] == p[0]) ? job_i.y0 : y1;
    end
  end

  for (genvar py = 0; py < 2; py++) begin : g_row
    for (genvar px = 0; px < 2; px++) begin : g_col
      logic [AW-1:0]       addr;
      logic                we;
      logic [PIX_BITS-1:0] rdata;
      assign addr = AW'(32'(ry[py] >> 1) * BW + 32'(cx[px] >> 1));
      assign we   = pop_o && job_i.is_load && job_i.load_ok &&
                    (job_i.x0[0] == 1'(px)) && (job_i.y0[0] == 1'(py));
      iuz_ram #(
        .WIDTH(PIX_BITS),
        .DEPTH(BDEPTH)
      ) u_bank (
        .clk_i  (clk_i),
        .we_i   (we),
        .waddr_i(addr),
        .wdata_i(job_i.pix),
        .re_i   (en),
        .raddr_i(addr),
        .rdata_o(rdata)
      );
      assign rd[py][px] = pixel_t'(rdata);
    end
  end

  // Stage 1: weights and neighbor selection flags, bank data arrives.
  logic [FRAC_BITS:0] ox, oy, fx_e, fy_e;
  logic               v1_q, err1_q, px1_q, py1_q, xs1_q, ys1_q;
  wgt_t               w1_q[4];

  always_comb begin
    fx_e = {1'b0, job_i.fx};
    fy_e = {1'b0, job_i.fy};
    ox   = {1'b1, {FRAC_BITS{1'b0}}} - fx_e;
    oy   = {1'b1, {FRAC_BITS{1'b0}}} - fy_e;
  end

  // Stage 2: sixteen products; stage 3: pair sums.
  pixel_t nb[4];
  logic   v2_q, err2_q, v3_q, err3_q;
  acc_t   prod_q[4][4];
  acc_t   sab_q[4], scd_q[4];

  always_comb begin
    nb[0] = rd[py1_q][px1_q];
    nb[1] = xs1_q ? rd[py1_q][px1_q] : rd[py1_q][!px1_q];
    nb[2] = ys1_q ? rd[py1_q][px1_q] : rd[!py1_q][px1_q];
    nb[3] = rd[ys1_q ? py1_q : !py1_q][xs1_q ? px1_q : !px1_q];
  end

  // Output: round half up to Q0.16 and saturate; error jobs give zero.
  acc_t                tot[4];
  logic [ACC_BITS-2*FRAC_BITS-1:0] rnd[4];
  pixel_t              res;
  logic                out_valid_q;
  out_item_t           out_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tot[c] = sab_q[c] + scd_q[c] + (ACC_BITS'(1) << (2 * FRAC_BITS - 1));
      rnd[c] = tot[c][ACC_BITS-1:2*FRAC_BITS];
      if (err3_q) begin
        res[c] = '0;
      end else if (rnd[c] > (ACC_BITS-2*FRAC_BITS)'({CH_BITS{1'b1}})) begin
        res[c] = {CH_BITS{1'b1}};
      end else begin
        res[c] = rnd[c][CH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop_o && !job_i.is_load;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err1_q <= job_i.err;
      px1_q  <= job_i.x0[0];
      py1_q  <= job_i.y0[0];
      xs1_q  <= job_i.x_same;
      ys1_q  <= job_i.y_same;
      w1_q[0] <= W_BITS'(oy * ox);
      w1_q[1] <= W_BITS'(oy * fx_e);
      w1_q[2] <= W_BITS'(fy_e * ox);
      w1_q[3] <= W_BITS'(fy_e * fx_e);
      err2_q <= err1_q;
      for (int c = 0; c < 4; c++) begin
        for (int n = 0; n < 4; n++) begin
          prod_q[c][n] <= ACC_BITS'(nb[n][c] * w1_q[n]);
        end
      end
      err3_q <= err2_q;
      for (int c = 0; c < 4; c++) begin
        sab_q[c] <= prod_q[c][0] + prod_q[c][1];
        scd_q[c] <= prod_q[c][2] + prod_q[c][3];
      end
      out_q.red_out    <= res[3];
      out_q.green_out  <= res[2];
      out_q.blue_out   <= res[1];
      out_q.alpha_out  <= res[0];
      out_q.dims_error <= err3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/image_upscale_zoom.sv
`timescale 1ns / 1ps
// Top level of the image upscaler: configuration registers, address front,
// job queue and datapath back. Uses iuz_pkg, iuz_front, iuz_fifo, iuz_back.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_data_i  (in_item_t)
//   out       output     out_valid_o/out_ready_i out_data_o (out_item_t)
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One item per cycle while out_ready_i holds. Produce items pass input, product
// and divider registers (one quotient bit per divider stage), the queue, and the
// weight, product, sum and output registers; loads write the store when popped.
// Reset clears all control state; the source store is not cleared.
// An output stall freezes the back, then fills the queue, then stops the front.
module image_upscale_zoom
  import iuz_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_data_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w    <= SDIM_BITS'(1);
      cfg_q.src_h    <= SDIM_BITS'(1);
      cfg_q.tgt_w    <= TDIM_BITS'(1);
      cfg_q.tgt_h    <= TDIM_BITS'(1);
      cfg_q.bilinear <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_W:    cfg_q.src_w    <= cfg_data_i[SDIM_BITS-1:0];
        CFG_SRC_H:    cfg_q.src_h    <= cfg_data_i[SDIM_BITS-1:0];
        CFG_TGT_W:    cfg_q.tgt_w    <= cfg_data_i[TDIM_BITS-1:0];
        CFG_TGT_H:    cfg_q.tgt_h    <= cfg_data_i[TDIM_BITS-1:0];
        CFG_BILINEAR: cfg_q.bilinear <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic q_space, q_push, q_avail, q_pop;
  job_t push_job, head_job;

  iuz_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_space_i (q_space),
    .q_push_o  (q_push),
    .q_job_o   (push_job)
  );

  iuz_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .space_o(q_space),
    .pop_i  (q_pop),
    .avail_o(q_avail),
    .job_o  (head_job)
  );

  iuz_back #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (q_avail),
    .job_i      (head_job),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: src/iuz_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the image upscaler, bound to the top level.
// Uses iuz_pkg for the payload types.
module iuz_checker
  import iuz_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dims_error |->
      out_data_o.red_out == '0 && out_data_o.green_out == '0 &&
      out_data_o.blue_out == '0 && out_data_o.alpha_out == '0)
    else $error("error beat carries nonzero channels");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind image_upscale_zoom iuz_checker u_iuz_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for image_upscale_zoom: loads source pixels, requests
// output pixels in nearest and bilinear modes and checks every result beat.
// Depends on iuz_pkg and the image_upscale_zoom RTL.
module testbench;
  import iuz_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE      = 64;
  localparam int MAX_SW      = DEF_MAX_SOURCE_WIDTH;
  localparam int MAX_SH      = DEF_MAX_SOURCE_HEIGHT;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  in_item_t                 in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  out_item_t                out_data_o;

  always #6 clk_i = ~clk_i;

  image_upscale_zoom dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // Shadow registers and source image as the bench sees them
  int unsigned src_w = 1, src_h = 1, tgt_w = 1, tgt_h = 1, bilinear = 0;
  logic [63:0] src_image [int];
  bit          queued_load [int];

  in_item_t  pending_q [$];
  out_item_t pixel_exp_q [$];
  int        mismatches = 0;
  int        idle_mode = 0;
  bit        hold_req = 0;
  int        hold_cnt = 0;
  int        cycles = 0;

  function automatic bit dims_valid();
    int unsigned lo;
    lo = bilinear ? 2 : 1;
    if (src_w < lo || src_w > MAX_SW || src_h < lo || src_h > MAX_SH) return 0;
    if (tgt_w < lo || tgt_w > MAX_TARGET_DIM) return 0;
    if (tgt_h < lo || tgt_h > MAX_TARGET_DIM) return 0;
    return (src_w <= tgt_w) && (src_h <= tgt_h);
  endfunction

  // Split i*(s-1)/(t-1) into integer part, clamped neighbor and Q0.16 fraction
  function automatic void split_pos(int unsigned i, int unsigned s, int unsigned t,
                                    output int unsigned lo, output int unsigned hi,
                                    output int unsigned frac);
    int unsigned num, den, q, r;
    num = i * (s - 1);
    den = t - 1;
    q = num / den;
    r = num % den;
    lo = q;
    hi = (q + 1 < s) ? q + 1 : s - 1;
    frac = (r << FRAC_BITS) / den;
  endfunction

  function automatic void source_pos(int unsigned tx_raw, int unsigned ty_raw,
                                     output int unsigned x0, output int unsigned x1,
                                     output int unsigned y0, output int unsigned y1,
                                     output int unsigned fx, output int unsigned fy);
    int unsigned tx, ty;
    tx = (tx_raw > tgt_w - 1) ? tgt_w - 1 : tx_raw;
    ty = (ty_raw > tgt_h - 1) ? tgt_h - 1 : ty_raw;
    if (bilinear) begin
      split_pos(tx, src_w, tgt_w, x0, x1, fx);
      split_pos(ty, src_h, tgt_h, y0, y1, fy);
    end else begin
      x0 = (tx * src_w) / tgt_w;
      y0 = (ty * src_h) / tgt_h;
      x1 = x0;
      y1 = y0;
      fx = 0;
      fy = 0;
    end
  endfunction

  function automatic logic [63:0] src_pixel(int unsigned x, int unsigned y);
    int a;
    a = y * MAX_SW + x;
    return src_image.exists(a) ? src_image[a] : 64'd0;
  endfunction

  function automatic out_item_t upscale(in_item_t it);
    out_item_t   res;
    int unsigned x0, x1, y0, y1, fx, fy;
    longint unsigned wa, wb, wc, wd, acc;
    logic [63:0] pa, pb, pc, pd;
    logic [15:0] ch [4];
    res = '0;
    if (!dims_valid()) begin
      res.dims_error = 1'b1;
      return res;
    end
    source_pos(32'(it.target_x), 32'(it.target_y), x0, x1, y0, y1, fx, fy);
    pa = src_pixel(x0, y0);
    pb = src_pixel(x1, y0);
    pc = src_pixel(x0, y1);
    pd = src_pixel(x1, y1);
    wa = longint'(65536 - fy) * (65536 - fx);
    wb = longint'(65536 - fy) * fx;
    wc = longint'(fy) * (65536 - fx);
    wd = longint'(fy) * fx;
    for (int c = 0; c < 4; c++) begin
      acc = pa[c*16 +: 16] * wa + pb[c*16 +: 16] * wb
          + pc[c*16 +: 16] * wc + pd[c*16 +: 16] * wd;
      acc = (acc + 64'h8000_0000) >> 32;
      ch[c] = (acc > 65535) ? 16'hFFFF : acc[15:0];
    end
    res.red_out   = ch[3];
    res.green_out = ch[2];
    res.blue_out  = ch[1];
    res.alpha_out = ch[0];
    return res;
  endfunction

  function automatic bit roll(int idle_pct);
    return $urandom_range(99) >= idle_pct;
  endfunction

  // Driver: record accepted beats, then offer the next pending item
  always @(posedge clk_i) begin
    bit       nv;
    in_item_t nxt;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (in_data_i.mode == MODE_LOAD)
          src_image[in_data_i.source_y * MAX_SW + in_data_i.source_x] =
            {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in, in_data_i.alpha_in};
        else
          pixel_exp_q.push_back(upscale(in_data_i));
      end
      nv = in_valid_i && !in_ready_o;
      if (!nv && pending_q.size() > 0 &&
          roll(idle_mode == 0 ? 36 : idle_mode == 1 ? 87 : 0)) begin
        nxt = pending_q.pop_front();
        in_data_i <= nxt;
        nv = 1'b1;
      end
      in_valid_i <= nv;
    end
  end

  // Long receiver stall: count the held cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_cnt <= 500;
      end
    end
  end

  // Monitor: check result beats against the oldest expected pixel
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pixel_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %p", out_data_o);
        end else begin
          want = pixel_exp_q.pop_front();
          if (out_data_o.red_out !== want.red_out || out_data_o.green_out !== want.green_out
              || out_data_o.blue_out !== want.blue_out
              || out_data_o.alpha_out !== want.alpha_out
              || out_data_o.dims_error !== want.dims_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
      if (hold_req || hold_cnt > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= roll(idle_mode == 0 ? 87 : idle_mode == 1 ? 36 : 0);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DATA_BITS-1:0];
    case (idx)
      CFG_SRC_W:    src_w = val & 'h1FF;
      CFG_SRC_H:    src_h = val & 'h1FF;
      CFG_TGT_W:    tgt_w = val & 'h1FFF;
      CFG_TGT_H:    tgt_h = val & 'h1FFF;
      CFG_BILINEAR: bilinear = val & 1;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_dims(int unsigned sw, int unsigned sh, int unsigned tw,
                          int unsigned th, int unsigned bil);
    write_reg(CFG_SRC_W, sw);
    write_reg(CFG_SRC_H, sh);
    write_reg(CFG_TGT_W, tw);
    write_reg(CFG_TGT_H, th);
    write_reg(CFG_BILINEAR, bil);
  endtask

  // Wait for every expected pixel, then let loads still in flight land
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || pixel_exp_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.red_in   = rand_chan();
    it.green_in = rand_chan();
    it.blue_in  = rand_chan();
    it.alpha_in = rand_chan();
    return it;
  endfunction

  task automatic push_load(int unsigned x, int unsigned y);
    in_item_t it;
    it = rand_item();
    it.mode = MODE_LOAD;
    it.source_x = 8'(x);
    it.source_y = 8'(y);
    queued_load[y * MAX_SW + x] = 1;
    pending_q.push_back(it);
  endtask

  // Drop requests that would read a source pixel never loaded
  task automatic push_pixel(int unsigned tx, int unsigned ty);
    in_item_t    it;
    int unsigned x0, x1, y0, y1, fx, fy;
    it = rand_item();
    it.mode = MODE_PRODUCE;
    it.target_x = 12'(tx);
    it.target_y = 12'(ty);
    if (dims_valid()) begin
      source_pos(tx, ty, x0, x1, y0, y1, fx, fy);
      if (!queued_load.exists(y0 * MAX_SW + x0) || !queued_load.exists(y0 * MAX_SW + x1)
          || !queued_load.exists(y1 * MAX_SW + x0) || !queued_load.exists(y1 * MAX_SW + x1))
        return;
    end
    pending_q.push_back(it);
  endtask

  task automatic load_area(int unsigned sw, int unsigned sh);
    for (int y = 0; y < sh; y++)
      for (int x = 0; x < sw; x++)
        push_load(x, y);
  endtask

  task automatic corners();
    push_pixel(0, 0);
    push_pixel(tgt_w - 1, tgt_h - 1);
    push_pixel(tgt_w / 2, tgt_h / 3);
    push_pixel(12'hFFF, 12'hFFF);
  endtask

  initial begin
    int unsigned sw, sh, tw, th;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small image in both modes, clamped coordinates
    set_dims(4, 3, 9, 7, 0);
    load_area(4, 3);
    corners();
    drain();
    write_reg(CFG_BILINEAR, 1);
    corners();
    push_pixel(1, 5);
    drain();

    // Invalid dimension sets: zero, too large, source above target, bilinear size 1
    set_dims(0, 3, 9, 7, 0);
    push_pixel(1, 1);
    drain();
    set_dims(300, 3, 8191, 7, 0);
    push_pixel(1, 1);
    drain();
    set_dims(4, 3, 3, 7, 0);
    push_pixel(2, 2);
    drain();
    set_dims(1, 3, 5, 0, 0);
    push_pixel(2, 2);
    drain();
    set_dims(1, 3, 5, 7, 1);
    write_reg(cfg_idx_e'(3'd6), 13'h1FFF);
    push_pixel(2, 2);
    drain();

    // Widest source against the largest target; load the columns reached below
    set_dims(256, 2, 4096, 4096, 1);
    for (int y = 0; y < 2; y++) begin
      push_load(0, y);
      push_load(1, y);
      push_load(127, y);
      push_load(128, y);
      push_load(255, y);
    end
    corners();
    push_pixel(2047, 1234);
    drain();
    set_dims(256, 1, 4096, 1, 0);
    corners();
    drain();
    set_dims(1, 256, 1, 4096, 0);
    push_load(0, 0);
    push_load(0, 85);
    push_load(0, 187);
    push_load(0, 255);
    corners();
    push_pixel(0, 3000);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = ph / 4;
      if ($urandom_range(9) == 0) begin
        set_dims($urandom_range(511), $urandom_range(511), $urandom_range(8191),
                 $urandom_range(8191), $urandom_range(1));
      end else begin
        sw = $urandom_range(8, 1);
        sh = $urandom_range(8, 1);
        tw = ($urandom_range(5) == 0) ? 4096 : $urandom_range(64, sw);
        th = ($urandom_range(5) == 0) ? 4096 : $urandom_range(64, sh);
        if ($urandom_range(1) && sw > 1 && sh > 1) set_dims(sw, sh, tw, th, 1);
        else set_dims(sw, sh, tw, th, 0);
        load_area(sw, sh);
      end
      if (ph == 9) hold_req = 1;
      for (int n = 0; n < ((ph == 9) ? 60 : 26); n++) begin
        if ($urandom_range(9) == 0)
          push_load($urandom_range(255), $urandom_range(255));
        else if ($urandom_range(9) == 0)
          push_pixel($urandom_range(4095), $urandom_range(4095));
        else
          push_pixel($urandom_range(tgt_w > 0 ? tgt_w - 1 : 0),
                     $urandom_range(tgt_h > 0 ? tgt_h - 1 : 0));
      end
      drain();
    end

    if (mismatches == 0 && pixel_exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
